FILE: rtl/lasm_pkg.sv
// Package for the line assembler: command kinds, register map, control bytes
// and the event record passed from the framer to the queue logic.
// No dependencies.
`default_nettype none

package lasm_pkg;

    // Command kinds carried on i_kind
    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_WRITE_START = 3'd1;
    localparam logic [2:0] KIND_POP        = 3'd2;
    localparam logic [2:0] KIND_DISCONNECT = 3'd3;
    localparam logic [2:0] KIND_FLUSH      = 3'd4;

    // Register index of the enable register (taken from paddr[2])
    localparam logic REG_ENABLED = 1'b0;

    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_SPC  = 8'h20;

    // Offsets and lengths within one line; lines are at most 64 bytes
    localparam int LINE_OFS_W = 6;
    localparam int LINE_LEN_W = 7;

    typedef logic [LINE_OFS_W-1:0] t_line_ofs;
    typedef logic [LINE_LEN_W-1:0] t_line_len;

    // One cycle of framer activity
    typedef struct packed {
        logic      wr_en;      // store a byte of the partial line
        t_line_ofs wr_ofs;     // its position in the line
        logic [7:0] wr_byte;
        logic      push;       // a finished, non-empty line
        t_line_ofs push_start; // first kept byte after trimming
        t_line_len push_len;   // kept length after trimming
    } t_frame_evt;

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] c);
        return (c == BYTE_SPC) || ((c >= BYTE_TAB) && (c <= BYTE_CR));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/line_assembler_with_drop_oldest_queue.sv
// Line assembler with a drop-oldest line queue. Data bytes, write starts,
// disconnects and flushes do not raise busy and may follow back to back.
// A pop of a line keeps busy high while its descriptor is read and while its
// characters stream out; results follow the descriptor read, one per cycle.
// An empty-queue pop gives its single result in the cycle after acceptance.
// Synchronous active-low reset empties the queue and clears all counters.
`default_nettype none

module line_assembler_with_drop_oldest_queue
    import lasm_pkg::*;
#(
    parameter int LINE_MAX    = 64,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    // result channel
    output      logic        o_valid,
    output      logic        o_has_line,
    output      logic [7:0]  o_char_out,
    output      logic        o_last,
    output      logic [3:0]  o_pending,
    output      logic [31:0] o_write_total,
    output      logic [31:0] o_line_total,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    // The ring has one slot more than the queue can hold: the spare slot is
    // always free and takes the partial line in place, so a finished line
    // never has to be copied and eviction never touches the line being built.
    localparam int SLOTS  = QUEUE_DEPTH + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(SLOTS * LINE_MAX);

    // ---------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------
    logic accept;
    logic cmd_data, cmd_wstart, cmd_pop, cmd_clear, cmd_flush;
    logic r_enabled;

    assign accept     = start && !busy;
    assign cmd_data   = accept && (i_kind == KIND_DATA) && r_enabled;
    assign cmd_wstart = accept && (i_kind == KIND_WRITE_START) && r_enabled;
    assign cmd_pop    = accept && (i_kind == KIND_POP);
    assign cmd_flush  = accept && (i_kind == KIND_FLUSH);
    // Disconnect and flush both drop the partial line, enabled or not
    assign cmd_clear  = accept && ((i_kind == KIND_DISCONNECT) || (i_kind == KIND_FLUSH));

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENABLED);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENABLED) ? {31'd0, r_enabled} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (cfg_wr) begin
            r_enabled <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------
    // Partial line framing
    // ---------------------------------------------------------------
    t_frame_evt evt;

    lasm_framer #(
        .LINE_MAX (LINE_MAX)
    ) u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (cmd_data),
        .i_byte    (i_data_byte),
        .i_clear   (cmd_clear),
        .o_evt     (evt)
    );

    // ---------------------------------------------------------------
    // Ring pointers and counters
    // ---------------------------------------------------------------
    logic [SLOT_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_write_total, r_line_total;
    logic              queue_full;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign queue_full = (r_count == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr          <= '0;
            r_rd          <= '0;
            r_count       <= '0;
            r_write_total <= '0;
            r_line_total  <= '0;
        end else begin
            if (cmd_wstart) begin
                r_write_total <= r_write_total + 32'd1;
            end
            priority if (cmd_flush) begin
                // empty the ring, keep the write and line totals
                r_wr    <= '0;
                r_rd    <= '0;
                r_count <= '0;
            end else if (evt.push) begin
                // commit the partial slot; evict the oldest line when full
                r_wr         <= slot_inc(r_wr);
                r_line_total <= r_line_total + 32'd1;
                if (queue_full) begin
                    r_rd <= slot_inc(r_rd);
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end else if (cmd_pop && (r_count != '0)) begin
                // advance past the line being popped
                r_rd    <= slot_inc(r_rd);
                r_count <= r_count - 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Storage and pop sequencing
    // ---------------------------------------------------------------
    logic              chr_re;
    logic [ADDR_W-1:0] chr_raddr;
    logic [ADDR_W-1:0] chr_waddr;
    logic [7:0]        chr_rdata;
    t_line_ofs         dsc_rstart;
    t_line_len         dsc_rlen;

    // Bytes of the partial line go straight into the free slot
    assign chr_waddr = ADDR_W'(r_wr) * ADDR_W'(LINE_MAX) + ADDR_W'(evt.wr_ofs);

    lasm_store #(
        .SLOTS    (SLOTS),
        .LINE_MAX (LINE_MAX)
    ) u_store (
        .i_clk        (i_clk),
        .i_chr_we     (evt.wr_en),
        .i_chr_waddr  (chr_waddr),
        .i_chr_wdata  (evt.wr_byte),
        .i_chr_re     (chr_re),
        .i_chr_raddr  (chr_raddr),
        .o_chr_rdata  (chr_rdata),
        .i_dsc_we     (evt.push),
        .i_dsc_wslot  (r_wr),
        .i_dsc_wstart (evt.push_start),
        .i_dsc_wlen   (evt.push_len),
        .i_dsc_re     (cmd_pop),
        .i_dsc_rslot  (r_rd),
        .o_dsc_rstart (dsc_rstart),
        .o_dsc_rlen   (dsc_rlen)
    );

    lasm_reader #(
        .SLOTS    (SLOTS),
        .LINE_MAX (LINE_MAX)
    ) u_reader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (cmd_pop),
        .i_empty     (r_count == '0),
        .i_slot      (r_rd),
        .i_dsc_start (dsc_rstart),
        .i_dsc_len   (dsc_rlen),
        .i_chr       (chr_rdata),
        .o_chr_re    (chr_re),
        .o_chr_raddr (chr_raddr),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_has_line  (o_has_line),
        .o_char_out  (o_char_out),
        .o_last      (o_last)
    );

    // Pending reflects the count after the pop; totals hold during a pop
    assign o_pending     = 4'(r_count);
    assign o_write_total = r_write_total;
    assign o_line_total  = r_line_total;

endmodule

`default_nettype wire

FILE: rtl/lasm_store.sv
// Line storage: a character memory holding one line per slot and a
// descriptor memory with the trimmed start and length of each slot.
// Depends on lasm_pkg.
`default_nettype none

module lasm_store
    import lasm_pkg::*;
#(
    parameter int SLOTS    = 9,
    parameter int LINE_MAX = 64,
    localparam int ADDR_W  = $clog2(SLOTS * LINE_MAX),
    localparam int SLOT_W  = $clog2(SLOTS)
) (
    input  wire logic              i_clk,
    // character port
    input  wire logic              i_chr_we,
    input  wire logic [ADDR_W-1:0] i_chr_waddr,
    input  wire logic [7:0]        i_chr_wdata,
    input  wire logic              i_chr_re,
    input  wire logic [ADDR_W-1:0] i_chr_raddr,
    output      logic [7:0]        o_chr_rdata,
    // descriptor port
    input  wire logic              i_dsc_we,
    input  wire logic [SLOT_W-1:0] i_dsc_wslot,
    input  wire t_line_ofs         i_dsc_wstart,
    input  wire t_line_len         i_dsc_wlen,
    input  wire logic              i_dsc_re,
    input  wire logic [SLOT_W-1:0] i_dsc_rslot,
    output      t_line_ofs         o_dsc_rstart,
    output      t_line_len         o_dsc_rlen
);

    logic [7:0]                     chr_mem [SLOTS*LINE_MAX];
    logic [LINE_OFS_W+LINE_LEN_W-1:0] dsc_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_chr_we) begin
            chr_mem[i_chr_waddr] <= i_chr_wdata;
        end
        if (i_chr_re) begin
            o_chr_rdata <= chr_mem[i_chr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dsc_we) begin
            dsc_mem[i_dsc_wslot] <= {i_dsc_wstart, i_dsc_wlen};
        end
        if (i_dsc_re) begin
            {o_dsc_rstart, o_dsc_rlen} <= dsc_mem[i_dsc_rslot];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lasm_framer.sv
// Partial line assembly: tracks length, first zero byte and the span of
// non-blank bytes so that trimming is known the moment LF arrives.
// Depends on lasm_pkg.
`default_nettype none

module lasm_framer
    import lasm_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_byte_en,  // accepted data byte while enabled
    input  wire logic [7:0] i_byte,
    input  wire logic       i_clear,    // disconnect or flush
    output      t_frame_evt o_evt
);

    t_line_len r_len,   n_len;
    logic      r_zero,  n_zero;   // a zero byte ended the content
    logic      r_has,   n_has;    // a non-blank byte has been seen
    t_line_len r_first, n_first;  // index of the first non-blank byte
    t_line_len r_end,   n_end;    // one past the last non-blank byte

    always_comb begin
        n_len   = r_len;
        n_zero  = r_zero;
        n_has   = r_has;
        n_first = r_first;
        n_end   = r_end;
        o_evt   = '0;
        o_evt.wr_byte    = i_byte;
        o_evt.wr_ofs     = LINE_OFS_W'(r_len);
        o_evt.push_start = LINE_OFS_W'(r_first);
        o_evt.push_len   = r_end - r_first;

        if (i_clear) begin
            n_len  = '0;
            n_zero = 1'b0;
            n_has  = 1'b0;
        end else if (i_byte_en) begin
            if (i_byte == BYTE_CR) begin
                // skip
            end else if (i_byte == BYTE_LF) begin
                o_evt.push = r_has;
                n_len  = '0;
                n_zero = 1'b0;
                n_has  = 1'b0;
            end else if (r_len == LINE_LEN_W'(LINE_MAX)) begin
                // overlong: drop the line and this byte
                n_len  = '0;
                n_zero = 1'b0;
                n_has  = 1'b0;
            end else begin
                o_evt.wr_en = 1'b1;
                n_len = r_len + 1'b1;
                if (!r_zero) begin
                    if (i_byte == BYTE_NUL) begin
                        n_zero = 1'b1;
                    end else if (!is_blank(i_byte)) begin
                        if (!r_has) begin
                            n_has   = 1'b1;
                            n_first = r_len;
                        end
                        n_end = r_len + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_zero <= 1'b0;
            r_has  <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_zero <= n_zero;
            r_has  <= n_has;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_end   <= n_end;
    end

endmodule

`default_nettype wire

FILE: rtl/lasm_reader.sv
// Pop sequencer: reads a slot's descriptor, then streams its characters out
// of the character memory, one result per cycle.
// Depends on lasm_pkg.
`default_nettype none

module lasm_reader
    import lasm_pkg::*;
#(
    parameter int SLOTS    = 9,
    parameter int LINE_MAX = 64,
    localparam int ADDR_W  = $clog2(SLOTS * LINE_MAX),
    localparam int SLOT_W  = $clog2(SLOTS)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pop,      // accepted pop command
    input  wire logic              i_empty,    // queue held no line
    input  wire logic [SLOT_W-1:0] i_slot,     // slot of the oldest line
    input  wire t_line_ofs         i_dsc_start,
    input  wire t_line_len         i_dsc_len,
    input  wire logic [7:0]        i_chr,
    output      logic              o_chr_re,
    output      logic [ADDR_W-1:0] o_chr_raddr,
    output      logic              o_busy,
    output      logic              o_valid,
    output      logic              o_has_line,
    output      logic [7:0]        o_char_out,
    output      logic              o_last
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EMPTY  = 4'b0010,
        S_DESC   = 4'b0100,
        S_STREAM = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_slot,  n_slot;
    logic [ADDR_W-1:0]   r_addr,  n_addr;
    t_line_len           r_idx,   n_idx;
    t_line_len           r_len,   n_len;
    logic                final_chr;

    assign final_chr = (r_idx + 1'b1) == r_len;

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_len       = r_len;
        o_chr_re    = 1'b0;
        o_chr_raddr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop) begin
                    n_state = i_empty ? S_EMPTY : S_DESC;
                    n_slot  = i_slot;
                end
            end
            S_EMPTY: begin
                n_state = S_IDLE;
            end
            S_DESC: begin
                o_chr_re    = 1'b1;
                o_chr_raddr = ADDR_W'(r_slot) * ADDR_W'(LINE_MAX) + ADDR_W'(i_dsc_start);
                n_addr      = o_chr_raddr + 1'b1;
                n_len       = i_dsc_len;
                n_idx       = '0;
                n_state     = S_STREAM;
            end
            S_STREAM: begin
                if (final_chr) begin
                    n_state = S_IDLE;
                end else begin
                    o_chr_re = 1'b1;
                    n_addr   = r_addr + 1'b1;
                    n_idx    = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_addr <= n_addr;
        r_idx  <= n_idx;
        r_len  <= n_len;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_EMPTY) || (r_state == S_STREAM);
    assign o_has_line = (r_state == S_STREAM);
    assign o_char_out = (r_state == S_STREAM) ? i_chr : 8'h00;
    assign o_last     = (r_state == S_EMPTY) || ((r_state == S_STREAM) && final_chr);

endmodule

`default_nettype wire

FILE: rtl/lasm_checker.sv
// Port-level checks for the line assembler, attached to the top level by
// the bind statement at the end. Depends on lasm_pkg.
`default_nettype none

module lasm_port_checks
    import lasm_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  i_kind,
    input wire logic        o_valid,
    input wire logic        o_has_line,
    input wire logic [7:0]  o_char_out,
    input wire logic        o_last,
    input wire logic [3:0]  o_pending,
    input wire logic [31:0] o_line_total
);

    // An accepted pop always has busy high in the cycle after acceptance
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_POP)) |=> busy)
        else $error("pop accepted but block not busy");

    // Results only appear while a pop is in progress
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");

    // The empty-queue answer is a single zero result
    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_line) |-> (o_last && (o_char_out == 8'h00) && (o_pending == 4'd0)))
        else $error("malformed empty-queue result");

    // A line streams without gaps until its last character
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && o_has_line))
        else $error("gap inside a popped line");

    // Lines are only counted as a result of an accepted command
    a_line_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> $stable(o_line_total))
        else $error("line total moved without a command");

endmodule

bind line_assembler_with_drop_oldest_queue lasm_port_checks u_lasm_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_kind       (i_kind),
    .o_valid      (o_valid),
    .o_has_line   (o_has_line),
    .o_char_out   (o_char_out),
    .o_last       (o_last),
    .o_pending    (o_pending),
    .o_line_total (o_line_total)
);

`default_nettype wire
